[design/assert_macros.svh]
// assertion macros used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, sampled on aclk, off while in reset
`define RCOFT_ASSERT_SAME(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, sampled on aclk, off while in reset
`define RCOFT_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

[design/rcoft_pkg.sv]
// types and constants shared by the open file table modules
package rcoft_pkg;

    localparam int TABLE_ENTRIES_DEF = 16;

    localparam int OP_W       = 2;
    localparam int NODE_W     = 16;
    localparam int LINK_W     = 8;
    localparam int STAT_W     = 3;
    localparam int IDX_OUT_W  = 4;

    localparam logic [LINK_W-1:0] LINK_MAX = '1;

    typedef enum logic [OP_W-1:0] {
        OP_OPEN  = 2'd0,
        OP_CLOSE = 2'd1,
        OP_MARK  = 2'd2
    } op_t;

    typedef enum logic [STAT_W-1:0] {
        STAT_OK         = 3'd0,
        STAT_REFUSED    = 3'd1,
        STAT_FULL       = 3'd2,
        STAT_NOT_FOUND  = 3'd3,
        STAT_COUNT_FULL = 3'd4
    } stat_t;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_FLUSH,
        S_COMMIT
    } state_t;

    typedef struct packed {
        logic [NODE_W-1:0] node;
        logic [LINK_W-1:0] links;
        logic              doomed;
    } entry_t;

    typedef struct packed {
        logic start;
        logic scan;
        logic commit;
    } dp_cmd_t;

    typedef struct packed {
        logic last;
    } dp_sts_t;

endpackage

[design/rcoft_ctrl.sv]
// controller state machine for the open file table
module rcoft_ctrl (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    output logic               m_valid,
    input  logic               m_ready,
    input  rcoft_pkg::dp_sts_t sts,
    output rcoft_pkg::dp_cmd_t cmd
);
    import rcoft_pkg::*;

    state_t state_reg;
    state_t state_next;
    logic   m_valid_reg;
    logic   m_valid_next;
    logic   out_free;

    assign out_free = !m_valid_reg || m_ready;
    assign m_valid  = m_valid_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        s_ready    = 1'b0;
        case (state_reg)
            S_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    cmd.start  = 1'b1;
                    state_next = S_SCAN;
                end
            end
            S_SCAN: begin
                cmd.scan = 1'b1;
                if (sts.last) begin
                    state_next = S_FLUSH;
                end
            end
            S_FLUSH: begin
                state_next = S_COMMIT;
            end
            S_COMMIT: begin
                if (out_free) begin
                    cmd.commit = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
        if (cmd.commit) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end else begin
            m_valid_next = m_valid_reg;
        end
    end

endmodule

[design/rcoft_dp.sv]
// datapath: entry table, scan pipeline, update logic and result registers
module rcoft_dp #(
    parameter int TABLE_ENTRIES = rcoft_pkg::TABLE_ENTRIES_DEF
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  rcoft_pkg::dp_cmd_t                  cmd,
    output rcoft_pkg::dp_sts_t                  sts,
    input  logic [rcoft_pkg::OP_W-1:0]          s_operation,
    input  logic [rcoft_pkg::NODE_W-1:0]        s_file_node,
    output logic [rcoft_pkg::STAT_W-1:0]        m_status,
    output logic [rcoft_pkg::IDX_OUT_W-1:0]     m_entry_index,
    output logic [rcoft_pkg::LINK_W-1:0]        m_link_count,
    output logic                                m_deallocate,
    output logic [rcoft_pkg::NODE_W-1:0]        m_deallocate_node
);
    import rcoft_pkg::*;

    localparam int IW = $clog2(TABLE_ENTRIES);
    localparam int XW = (IW > IDX_OUT_W) ? IW : IDX_OUT_W;

    entry_t                 mem [TABLE_ENTRIES];
    logic [TABLE_ENTRIES-1:0] valid_reg;

    logic [OP_W-1:0]   op_reg;
    logic [NODE_W-1:0] node_reg;
    logic [IW-1:0]     cnt_reg;

    logic              pend_reg;
    logic              rd_vld_reg;
    logic [IW-1:0]     rd_idx_reg;
    entry_t            rd_word_reg;

    logic              match_found_reg;
    logic [IW-1:0]     match_idx_reg;
    logic [LINK_W-1:0] match_links_reg;
    logic              match_doomed_reg;
    logic              free_found_reg;
    logic [IW-1:0]     free_idx_reg;

    logic [STAT_W-1:0] m_status_reg;
    logic [IDX_OUT_W-1:0] m_entry_index_reg;
    logic [LINK_W-1:0] m_link_count_reg;
    logic              m_deallocate_reg;
    logic [NODE_W-1:0] m_deallocate_node_reg;

    logic              hit;
    logic [LINK_W-1:0] open_links;
    logic [LINK_W-1:0] close_links;

    logic              wr_en;
    logic [IW-1:0]     wr_idx;
    entry_t            wr_word;
    logic              set_valid;
    logic              clr_valid;
    stat_t             res_status;
    logic [IW-1:0]     res_idx;
    logic [XW-1:0]     res_idx_x;
    logic [LINK_W-1:0] res_links;
    logic              res_dealloc;
    logic [NODE_W-1:0] res_dnode;

    assign sts.last = (cnt_reg == IW'(TABLE_ENTRIES - 1));

    assign hit = pend_reg && rd_vld_reg && !match_found_reg
                 && (rd_word_reg.node == node_reg);

    assign open_links  = match_links_reg + LINK_W'(1);
    assign close_links = (match_links_reg != '0) ? (match_links_reg - LINK_W'(1)) : '0;
    assign res_idx_x   = XW'(res_idx);

    // control state of the scan and the valid bits
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg         <= '0;
            pend_reg        <= 1'b0;
            match_found_reg <= 1'b0;
            free_found_reg  <= 1'b0;
            valid_reg       <= '0;
        end else begin
            pend_reg <= cmd.scan;
            if (cmd.start) begin
                cnt_reg         <= '0;
                match_found_reg <= 1'b0;
                free_found_reg  <= 1'b0;
            end else begin
                if (cmd.scan) begin
                    cnt_reg <= cnt_reg + IW'(1);
                    if (!free_found_reg && !valid_reg[cnt_reg]) begin
                        free_found_reg <= 1'b1;
                    end
                end
                if (hit) begin
                    match_found_reg <= 1'b1;
                end
            end
            if (cmd.commit && set_valid) begin
                valid_reg[wr_idx] <= 1'b1;
            end
            if (cmd.commit && clr_valid) begin
                valid_reg[wr_idx] <= 1'b0;
            end
        end
    end

    // table memory, one read and one write port
    always_ff @(posedge aclk) begin
        if (cmd.commit && wr_en) begin
            mem[wr_idx] <= wr_word;
        end
        rd_word_reg <= mem[cnt_reg];
    end

    always_ff @(posedge aclk) begin
        if (cmd.start) begin
            op_reg   <= s_operation;
            node_reg <= s_file_node;
        end
        rd_vld_reg <= valid_reg[cnt_reg];
        rd_idx_reg <= cnt_reg;
        if (cmd.scan && !free_found_reg && !valid_reg[cnt_reg]) begin
            free_idx_reg <= cnt_reg;
        end
        if (hit && !cmd.start) begin
            match_idx_reg    <= rd_idx_reg;
            match_links_reg  <= rd_word_reg.links;
            match_doomed_reg <= rd_word_reg.doomed;
        end
        if (cmd.commit) begin
            m_status_reg          <= res_status;
            m_entry_index_reg     <= res_idx_x[IDX_OUT_W-1:0];
            m_link_count_reg      <= res_links;
            m_deallocate_reg      <= res_dealloc;
            m_deallocate_node_reg <= res_dnode;
        end
    end

    // operation decode and table update
    always_comb begin
        wr_en       = 1'b0;
        wr_idx      = match_idx_reg;
        wr_word     = '{node: node_reg, links: match_links_reg, doomed: match_doomed_reg};
        set_valid   = 1'b0;
        clr_valid   = 1'b0;
        res_status  = STAT_NOT_FOUND;
        res_idx     = '0;
        res_links   = '0;
        res_dealloc = 1'b0;
        res_dnode   = '0;
        case (op_t'(op_reg))
            OP_OPEN: begin
                if (match_found_reg) begin
                    res_idx   = match_idx_reg;
                    res_links = match_links_reg;
                    if (match_doomed_reg) begin
                        res_status = STAT_REFUSED;
                    end else if (match_links_reg == LINK_MAX) begin
                        res_status = STAT_COUNT_FULL;
                    end else begin
                        res_status    = STAT_OK;
                        res_links     = open_links;
                        wr_en         = 1'b1;
                        wr_word.links = open_links;
                    end
                end else if (free_found_reg) begin
                    res_status = STAT_OK;
                    res_idx    = free_idx_reg;
                    res_links  = LINK_W'(1);
                    wr_en      = 1'b1;
                    wr_idx     = free_idx_reg;
                    wr_word    = '{node: node_reg, links: LINK_W'(1), doomed: 1'b0};
                    set_valid  = 1'b1;
                end else begin
                    res_status = STAT_FULL;
                end
            end
            OP_CLOSE: begin
                if (match_found_reg) begin
                    res_status = STAT_OK;
                    res_idx    = match_idx_reg;
                    res_links  = close_links;
                    if (close_links == '0) begin
                        clr_valid   = 1'b1;
                        res_dealloc = match_doomed_reg;
                        res_dnode   = match_doomed_reg ? node_reg : '0;
                    end else begin
                        wr_en         = 1'b1;
                        wr_word.links = close_links;
                    end
                end
            end
            OP_MARK: begin
                if (match_found_reg) begin
                    res_status     = STAT_OK;
                    res_idx        = match_idx_reg;
                    res_links      = match_links_reg;
                    wr_en          = 1'b1;
                    wr_word.doomed = 1'b1;
                end
            end
            default: begin
                res_status = STAT_NOT_FOUND;
            end
        endcase
    end

    assign m_status          = m_status_reg;
    assign m_entry_index     = m_entry_index_reg;
    assign m_link_count      = m_link_count_reg;
    assign m_deallocate      = m_deallocate_reg;
    assign m_deallocate_node = m_deallocate_node_reg;

endmodule

[design/refcounted_open_file_table.sv]
// Reference-counted open file table. One operation (open, close, mark for
// removal) is taken per transfer on the s_ channel and gives one result on the
// m_ channel. Each operation scans the table one entry per cycle through one
// read port of the entry memory; the result is loaded after the scan and a
// flush state, and a new operation is taken in the cycle after the result is
// loaded. The result register lets the next operation start while the previous
// result waits for m_ready; that operation then holds its result until the
// register is free. The table is empty after reset; no clearing pass is
// needed.
module refcounted_open_file_table #(
    parameter int TABLE_ENTRIES = rcoft_pkg::TABLE_ENTRIES_DEF
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_valid,
    output logic                                s_ready,
    input  logic [rcoft_pkg::OP_W-1:0]          s_operation,
    input  logic [rcoft_pkg::NODE_W-1:0]        s_file_node,
    output logic                                m_valid,
    input  logic                                m_ready,
    output logic [rcoft_pkg::STAT_W-1:0]        m_status,
    output logic [rcoft_pkg::IDX_OUT_W-1:0]     m_entry_index,
    output logic [rcoft_pkg::LINK_W-1:0]        m_link_count,
    output logic                                m_deallocate,
    output logic [rcoft_pkg::NODE_W-1:0]        m_deallocate_node
);
    import rcoft_pkg::*;

    dp_cmd_t cmd;
    dp_sts_t sts;

    rcoft_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .sts     (sts),
        .cmd     (cmd)
    );

    rcoft_dp #(
        .TABLE_ENTRIES (TABLE_ENTRIES)
    ) u_dp (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .cmd               (cmd),
        .sts               (sts),
        .s_operation       (s_operation),
        .s_file_node       (s_file_node),
        .m_status          (m_status),
        .m_entry_index     (m_entry_index),
        .m_link_count      (m_link_count),
        .m_deallocate      (m_deallocate),
        .m_deallocate_node (m_deallocate_node)
    );

endmodule

[design/rcoft_checker.sv]
// port-level checker for the open file table, bound to the top level
`include "assert_macros.svh"

module rcoft_checker (
    input logic                                aclk,
    input logic                                aresetn,
    input logic                                s_valid,
    input logic                                s_ready,
    input logic [rcoft_pkg::OP_W-1:0]          s_operation,
    input logic [rcoft_pkg::NODE_W-1:0]        s_file_node,
    input logic                                m_valid,
    input logic                                m_ready,
    input logic [rcoft_pkg::STAT_W-1:0]        m_status,
    input logic [rcoft_pkg::IDX_OUT_W-1:0]     m_entry_index,
    input logic [rcoft_pkg::LINK_W-1:0]        m_link_count,
    input logic                                m_deallocate,
    input logic [rcoft_pkg::NODE_W-1:0]        m_deallocate_node
);
    import rcoft_pkg::*;

    logic in_stall;
    logic in_take;
    logic out_stall;
    logic dealloc_out;
    logic failed_lookup;
    logic fields_zero;
    logic [OP_W+NODE_W-1:0] in_word;
    logic [STAT_W+IDX_OUT_W+LINK_W+NODE_W:0] out_word;

    assign in_stall      = s_valid && !s_ready;
    assign in_take       = s_valid && s_ready;
    assign out_stall     = m_valid && !m_ready;
    assign dealloc_out   = m_valid && m_deallocate;
    assign failed_lookup = m_valid && (m_status == STAT_FULL || m_status == STAT_NOT_FOUND);
    assign fields_zero   = m_entry_index == '0 && m_link_count == '0 && !m_deallocate
                           && m_deallocate_node == '0;
    assign in_word       = {s_operation, s_file_node};
    assign out_word      = {m_status, m_entry_index, m_link_count, m_deallocate,
                            m_deallocate_node};

    // stalled result holds
    `RCOFT_ASSERT_NEXT(a_out_hold, out_stall, m_valid && $stable(out_word), "result changed while stalled")

    // waiting input transfer holds
    `RCOFT_ASSERT_NEXT(a_in_hold, in_stall, s_valid && $stable(in_word), "input changed while waiting")

    // one operation at a time
    `RCOFT_ASSERT_NEXT(a_one_at_a_time, in_take, !s_ready, "input taken during a scan")

    // deallocate only with an OK status and a zero link count
    `RCOFT_ASSERT_SAME(a_dealloc_ok, dealloc_out, m_status == STAT_OK && m_link_count == '0, "bad deallocate")

    // failed lookups carry zero fields
    `RCOFT_ASSERT_SAME(a_fail_zero, failed_lookup, fields_zero, "nonzero fields on a failed lookup")

endmodule

bind refcounted_open_file_table rcoft_checker u_rcoft_checker (.*);
